@@ hdl/pmlsc_pkg.sv @@
package pmlsc_pkg;

    localparam int MV_W       = 14;
    localparam int MW_W       = 16;
    localparam int BOOST_W    = 8;
    localparam int MASK_W     = 32;
    localparam int CHARGE_W   = 14;
    localparam int REPORTED_W = 17;
    localparam int SWITCH_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_NOMINAL     = 2'd0,
        MODE_LOW_VOLTAGE = 2'd1,
        MODE_SAFE        = 2'd2,
        MODE_RECOVERY    = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_LOW_MV = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_MV     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUNRISE_MW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_MW         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_TICKS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHED_MASK       = 3'd5;

    localparam logic [MV_W-1:0]    RST_CRITICAL_LOW_MV = 14'd6800;
    localparam logic [MV_W-1:0]    RST_RECOVERY_MV     = 14'd7400;
    localparam logic [MW_W-1:0]    RST_SUNRISE_MW      = 16'd500;
    localparam logic [MW_W-1:0]    RST_DARK_MW         = 16'd100;
    localparam logic [BOOST_W-1:0] RST_BOOST_TICKS     = 8'd50;
    localparam logic [MASK_W-1:0]  RST_SHED_MASK       = 32'd6;

    // charge = floor((mv - 6000) * 25 / 6), via reciprocal 25 * 2^20 / 6 rounded up
    localparam logic [MV_W-1:0]     SOC_MIN_MV  = 14'd6000;
    localparam logic [MV_W-1:0]     SOC_MAX_MV  = 14'd8400;
    localparam logic [CHARGE_W-1:0] SOC_FULL    = 14'd10000;
    localparam int                  SOC_DELTA_W = 12;
    localparam int                  SOC_RECIP_W = 23;
    localparam logic [SOC_RECIP_W-1:0] SOC_RECIP = 23'd4369067;
    localparam int                  SOC_SHIFT   = 20;

    // boosted = floor(p * 9 / 5), via reciprocal 9 * 2^20 / 5 rounded up
    localparam int                      BOOST_RECIP_W = 21;
    localparam logic [BOOST_RECIP_W-1:0] BOOST_RECIP  = 21'd1887437;
    localparam int                      BOOST_SHIFT   = 20;

    typedef struct packed {
        logic [MV_W-1:0]    critical_low_mv;
        logic [MV_W-1:0]    recovery_mv;
        logic [MW_W-1:0]    sunrise_mw;
        logic [MW_W-1:0]    dark_mw;
        logic [BOOST_W-1:0] boost_ticks;
        logic [MASK_W-1:0]  shed_mask;
    } cfg_t;

    typedef struct packed {
        logic [MV_W-1:0] bus_voltage_mv;
        logic [MW_W-1:0] solar_power_mw;
    } item_t;

    typedef struct packed {
        mode_t                mode;
        logic [CHARGE_W-1:0]  charge_level;
        logic [REPORTED_W-1:0] reported_solar_mw;
        logic [SWITCH_W-1:0]  load_switches;
        logic                 safe_active;
        logic                 fault_raised;
        logic                 boosting;
    } result_t;

endpackage

@@ hdl/pmlsc_if.sv @@
interface pmlsc_item_if;
    import pmlsc_pkg::*;

    logic            valid;
    logic            ready;
    logic [MV_W-1:0] bus_voltage_mv;
    logic [MW_W-1:0] solar_power_mw;

    modport source (output valid, output bus_voltage_mv, output solar_power_mw, input ready);
    modport sink   (input valid, input bus_voltage_mv, input solar_power_mw, output ready);
endinterface

interface pmlsc_result_if;
    import pmlsc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            mode;
    logic [CHARGE_W-1:0]   charge_level;
    logic [REPORTED_W-1:0] reported_solar_mw;
    logic [SWITCH_W-1:0]   load_switches;
    logic                  safe_active;
    logic                  fault_raised;
    logic                  boosting;

    modport source (
        output valid, output mode, output charge_level, output reported_solar_mw,
        output load_switches, output safe_active, output fault_raised, output boosting,
        input ready
    );
    modport sink (
        input valid, input mode, input charge_level, input reported_solar_mw,
        input load_switches, input safe_active, input fault_raised, input boosting,
        output ready
    );
endinterface

interface pmlsc_cfg_if;
    import pmlsc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/pmlsc_cfg_regs.sv @@
module pmlsc_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    pmlsc_cfg_if.sink       cfg,
    output pmlsc_pkg::cfg_t regs
);
    import pmlsc_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_CRITICAL_LOW_MV: regs_next.critical_low_mv = cfg.data[MV_W-1:0];
                REG_RECOVERY_MV:     regs_next.recovery_mv     = cfg.data[MV_W-1:0];
                REG_SUNRISE_MW:      regs_next.sunrise_mw      = cfg.data[MW_W-1:0];
                REG_DARK_MW:         regs_next.dark_mw         = cfg.data[MW_W-1:0];
                REG_BOOST_TICKS:     regs_next.boost_ticks     = cfg.data[BOOST_W-1:0];
                REG_SHED_MASK:       regs_next.shed_mask       = cfg.data[MASK_W-1:0];
                default:             regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.critical_low_mv <= RST_CRITICAL_LOW_MV;
            regs_reg.recovery_mv     <= RST_RECOVERY_MV;
            regs_reg.sunrise_mw      <= RST_SUNRISE_MW;
            regs_reg.dark_mw         <= RST_DARK_MW;
            regs_reg.boost_ticks     <= RST_BOOST_TICKS;
            regs_reg.shed_mask       <= RST_SHED_MASK;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

@@ hdl/pmlsc_step.sv @@
module pmlsc_step #(
    parameter int SWITCH_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  pmlsc_pkg::item_t   item,
    input  pmlsc_pkg::cfg_t    regs,
    output pmlsc_pkg::result_t result
);
    import pmlsc_pkg::*;

    localparam int SOC_PROD_W   = SOC_DELTA_W + SOC_RECIP_W;
    localparam int BOOST_PROD_W = MW_W + BOOST_RECIP_W;

    mode_t                  mode_reg, mode_next;
    logic [MW_W-1:0]        prev_solar_reg;
    logic [BOOST_W-1:0]     boost_left_reg, boost_left_next;
    logic [SWITCH_BITS-1:0] switch_reg, switch_next;
    logic                   safe_flag_reg, safe_flag_next;

    logic                   sunrise;
    logic [BOOST_W-1:0]     boost_cur;
    logic                   boosting;
    logic                   fault;
    logic [SWITCH_BITS-1:0] mask;
    logic [SOC_DELTA_W-1:0] soc_delta;
    logic [SOC_PROD_W-1:0]  soc_prod;
    logic [CHARGE_W-1:0]    charge;
    logic [BOOST_PROD_W-1:0] boost_prod;
    logic [REPORTED_W-1:0]  reported;

    assign mask = SWITCH_BITS'(regs.shed_mask);

    // charge level
    assign soc_delta = SOC_DELTA_W'(item.bus_voltage_mv - SOC_MIN_MV);
    assign soc_prod  = SOC_PROD_W'(soc_delta) * SOC_PROD_W'(SOC_RECIP);

    always_comb
    begin
        priority if (item.bus_voltage_mv >= SOC_MAX_MV)
            charge = SOC_FULL;
        else if (item.bus_voltage_mv <= SOC_MIN_MV)
            charge = '0;
        else
            charge = CHARGE_W'(soc_prod >> SOC_SHIFT);
    end

    // sunrise and boost
    assign sunrise    = (item.solar_power_mw > regs.sunrise_mw) &&
                        (prev_solar_reg <= regs.dark_mw);
    assign boost_cur  = sunrise ? regs.boost_ticks : boost_left_reg;
    assign boosting   = (boost_cur != '0);
    assign boost_left_next = boosting ? boost_cur - 1'b1 : boost_cur;
    assign boost_prod = BOOST_PROD_W'(item.solar_power_mw) * BOOST_PROD_W'(BOOST_RECIP);
    assign reported   = boosting ? REPORTED_W'(boost_prod >> BOOST_SHIFT)
                                 : REPORTED_W'(item.solar_power_mw);

    // mode machine
    always_comb
    begin
        mode_next      = mode_reg;
        switch_next    = switch_reg;
        safe_flag_next = safe_flag_reg;
        fault          = 1'b0;
        unique case (mode_reg)
            MODE_NOMINAL:
            begin
                if (item.bus_voltage_mv < regs.critical_low_mv)
                begin
                    mode_next = MODE_LOW_VOLTAGE;
                    fault     = 1'b1;
                end
            end
            MODE_LOW_VOLTAGE:
            begin
                switch_next    = switch_reg & ~mask;
                mode_next      = MODE_SAFE;
                safe_flag_next = 1'b1;
            end
            MODE_SAFE:
            begin
                if (item.bus_voltage_mv >= regs.recovery_mv)
                begin
                    switch_next    = switch_reg | mask;
                    mode_next      = MODE_RECOVERY;
                    safe_flag_next = 1'b0;
                end
            end
            MODE_RECOVERY:
            begin
                mode_next = MODE_NOMINAL;
            end
            default:
            begin
                mode_next = MODE_NOMINAL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_NOMINAL;
            prev_solar_reg <= '0;
            boost_left_reg <= '0;
            switch_reg     <= '1;
            safe_flag_reg  <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg       <= mode_next;
            prev_solar_reg <= item.solar_power_mw;
            boost_left_reg <= boost_left_next;
            switch_reg     <= switch_next;
            safe_flag_reg  <= safe_flag_next;
        end
    end

    always_comb
    begin
        result.mode              = mode_next;
        result.charge_level      = charge;
        result.reported_solar_mw = reported;
        result.load_switches     = SWITCH_W'(switch_next);
        result.safe_active       = safe_flag_next;
        result.fault_raised      = fault;
        result.boosting          = boosting;
    end

    a_safe_flag_tracks_mode: assert property (@(posedge clk) disable iff (!rst_n)
        safe_flag_reg == (mode_reg == MODE_SAFE))
        else $error("safe flag out of step with mode");

    a_fault_enters_low: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.fault_raised |=> mode_reg == MODE_LOW_VOLTAGE)
        else $error("fault without entry to low voltage");

endmodule

@@ hdl/power_mode_load_shed_controller_core.sv @@
// Power mode and load shed controller. Each input transaction is one tick: bus voltage
// (mV) and solar power (mW). One result transaction comes out per tick with state of
// charge, solar power (x9/5 while the post-sunrise boost runs), the mode after the tick,
// the load switch register, the safe flag and a one-tick fault flag. Result valid rises
// once the registered input stage advances into the result register, which waits while a
// held result is not taken; one tick per cycle is accepted when the result side does not
// stall, with the mode/boost state update combinational between the input and result regs.
// Configuration writes take effect on the next processed tick and are accepted every cycle.
module power_mode_load_shed_controller_core #(
    parameter int SWITCH_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    pmlsc_cfg_if.sink     cfg,
    pmlsc_item_if.sink    item,
    pmlsc_result_if.source result
);
    import pmlsc_pkg::*;

    cfg_t    regs;
    item_t   item_reg, item_next;
    logic    item_valid_reg, item_valid_next;
    result_t result_reg, result_next;
    logic    result_valid_reg, result_valid_next;
    result_t step_result;
    logic    advance;

    pmlsc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pmlsc_step #(
        .SWITCH_BITS (SWITCH_BITS)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .regs   (regs),
        .result (step_result)
    );

    assign advance    = item_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;

    always_comb
    begin
        item_next         = item_reg;
        item_valid_next   = item_valid_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && result.ready)
            result_valid_next = 1'b0;
        if (advance)
        begin
            result_next       = step_result;
            result_valid_next = 1'b1;
            item_valid_next   = 1'b0;
        end
        if (item.valid && item.ready)
        begin
            item_next.bus_voltage_mv = item.bus_voltage_mv;
            item_next.solar_power_mw = item.solar_power_mw;
            item_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign result.valid             = result_valid_reg;
    assign result.mode              = result_reg.mode;
    assign result.charge_level      = result_reg.charge_level;
    assign result.reported_solar_mw = result_reg.reported_solar_mw;
    assign result.load_switches     = result_reg.load_switches;
    assign result.safe_active       = result_reg.safe_active;
    assign result.fault_raised      = result_reg.fault_raised;
    assign result.boosting          = result_reg.boosting;

    a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> item_valid_reg)
        else $error("accepted transaction not held in input stage");

    a_advance_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("processed tick did not produce a result");

endmodule

@@ sim/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pmlsc_pkg::*;

    localparam int MV_TOP      = (1 << MV_W) - 1;
    localparam int MW_TOP      = (1 << MW_W) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SOAK_PHASES = 9;
    localparam int PHASE_TICKS = 80;

    // indexes past the last register, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    pmlsc_cfg_if    cfg_if ();
    pmlsc_item_if   item_if ();
    pmlsc_result_if res_if ();

    power_mode_load_shed_controller_core #(
        .SWITCH_BITS(SWITCH_W)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .item  (item_if),
        .result(res_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // controller shadow state
    cfg_t                settings;
    mode_t               pm_mode;
    logic [MW_W-1:0]     last_solar;
    logic [BOOST_W-1:0]  boost_count;
    logic [SWITCH_W-1:0] switch_bank;
    logic                safe_bit;

    result_t pending_outcomes[$];
    int      mismatches   = 0;
    int      cycle_count  = 0;
    int      hold_request = 0;
    bit      idling_on    = 1'b1;

    function automatic cfg_t reset_settings();
        cfg_t c;
        c.critical_low_mv = RST_CRITICAL_LOW_MV;
        c.recovery_mv     = RST_RECOVERY_MV;
        c.sunrise_mw      = RST_SUNRISE_MW;
        c.dark_mw         = RST_DARK_MW;
        c.boost_ticks     = RST_BOOST_TICKS;
        c.shed_mask       = RST_SHED_MASK;
        return c;
    endfunction

    function automatic result_t predict_outcome(input item_t it);
        result_t     r;
        int unsigned mv;
        int unsigned pw;
        mv = it.bus_voltage_mv;
        pw = it.solar_power_mw;
        r.boosting          = 1'b0;
        r.fault_raised      = 1'b0;
        r.reported_solar_mw = REPORTED_W'(pw);

        // sunrise first, so it boosts the same tick
        if (pw > settings.sunrise_mw && last_solar <= settings.dark_mw)
            boost_count = settings.boost_ticks;
        last_solar = it.solar_power_mw;
        if (boost_count != 0)
        begin
            r.reported_solar_mw = REPORTED_W'(pw * 9 / 5);
            r.boosting          = 1'b1;
            boost_count--;
        end

        case (pm_mode)
            MODE_NOMINAL:
            begin
                if (mv < settings.critical_low_mv)
                begin
                    pm_mode        = MODE_LOW_VOLTAGE;
                    r.fault_raised = 1'b1;
                end
            end
            MODE_LOW_VOLTAGE:
            begin
                switch_bank = switch_bank & ~settings.shed_mask;
                pm_mode     = MODE_SAFE;
                safe_bit    = 1'b1;
            end
            MODE_SAFE:
            begin
                if (mv >= settings.recovery_mv)
                begin
                    switch_bank = switch_bank | settings.shed_mask;
                    pm_mode     = MODE_RECOVERY;
                    safe_bit    = 1'b0;
                end
            end
            default: pm_mode = MODE_NOMINAL;
        endcase

        if (mv >= SOC_MAX_MV)
            r.charge_level = SOC_FULL;
        else if (mv <= SOC_MIN_MV)
            r.charge_level = '0;
        else
            r.charge_level = CHARGE_W'((mv - SOC_MIN_MV) * SOC_FULL / (SOC_MAX_MV - SOC_MIN_MV));

        r.mode          = pm_mode;
        r.load_switches = switch_bank;
        r.safe_active   = safe_bit;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result transaction with no tick outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                compare_field("mode", want.mode, res_if.mode);
                compare_field("charge_level", want.charge_level, res_if.charge_level);
                compare_field("reported_solar_mw", want.reported_solar_mw,
                              res_if.reported_solar_mw);
                compare_field("load_switches", want.load_switches, res_if.load_switches);
                compare_field("safe_active", want.safe_active, res_if.safe_active);
                compare_field("fault_raised", want.fault_raised, res_if.fault_raised);
                compare_field("boosting", want.boosting, res_if.boosting);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("power_mode_load_shed_controller_core: mismatch");
            $finish;
        end
    end

    // result side: random stalls plus long hold-offs on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(99) < 13)
                res_if.ready <= 1'b0;
            else
                res_if.ready <= 1'b1;
        end
    end

    task automatic send_tick(input logic [MV_W-1:0] mv, input logic [MW_W-1:0] pw);
        int    gaps = 0;
        item_t it;
        it.bus_voltage_mv = mv;
        it.solar_power_mw = pw;
        if (idling_on)
            while ($urandom_range(99) < 13)
                gaps++;
        if (gaps > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        item_if.valid          <= 1'b1;
        item_if.bus_voltage_mv <= mv;
        item_if.solar_power_mw <= pw;
        do @(posedge clk); while (!item_if.ready);
        pending_outcomes.push_back(predict_outcome(it));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            REG_CRITICAL_LOW_MV: settings.critical_low_mv = val[MV_W-1:0];
            REG_RECOVERY_MV:     settings.recovery_mv     = val[MV_W-1:0];
            REG_SUNRISE_MW:      settings.sunrise_mw      = val[MW_W-1:0];
            REG_DARK_MW:         settings.dark_mw         = val[MW_W-1:0];
            REG_BOOST_TICKS:     settings.boost_ticks     = val[BOOST_W-1:0];
            REG_SHED_MASK:       settings.shed_mask       = val[MASK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input cfg_t c);
        write_reg(REG_CRITICAL_LOW_MV, CFG_DATA_W'(c.critical_low_mv));
        write_reg(REG_RECOVERY_MV, CFG_DATA_W'(c.recovery_mv));
        write_reg(REG_SUNRISE_MW, CFG_DATA_W'(c.sunrise_mw));
        write_reg(REG_DARK_MW, CFG_DATA_W'(c.dark_mw));
        write_reg(REG_BOOST_TICKS, CFG_DATA_W'(c.boost_ticks));
        write_reg(REG_SHED_MASK, c.shed_mask);
        write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
        cfg_if.valid <= 1'b0;
    endtask

    // block must be idle before any register write
    task automatic settle();
        item_if.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [MV_W-1:0] pick_voltage();
        int v;
        int sel;
        sel = $urandom_range(99);
        if (sel < 35)
            v = int'(settings.critical_low_mv) + int'($urandom_range(400)) - 200;
        else if (sel < 65)
            v = int'(settings.recovery_mv) + int'($urandom_range(400)) - 200;
        else if (sel < 80)
            v = ($urandom_range(1) ? int'(SOC_MIN_MV) : int'(SOC_MAX_MV))
                + int'($urandom_range(4)) - 2;
        else
            v = $urandom_range(MV_TOP);
        if (v < 0)
            v = 0;
        if (v > MV_TOP)
            v = MV_TOP;
        return MV_W'(v);
    endfunction

    function automatic logic [MW_W-1:0] pick_power(input bit sunny);
        int unsigned lo;
        if ($urandom_range(99) < 15)
            return MW_W'($urandom_range(MW_TOP));
        if (sunny)
        begin
            if (settings.sunrise_mw == '1)
                return '1;
            lo = settings.sunrise_mw + 1;
            return ($urandom_range(2) == 0) ? MW_W'(lo) : MW_W'($urandom_range(MW_TOP, lo));
        end
        return ($urandom_range(2) == 0) ? settings.dark_mw
                                        : MW_W'($urandom_range(settings.dark_mw));
    endfunction

    function automatic cfg_t random_settings();
        cfg_t        c;
        int unsigned rec;
        c.critical_low_mv = MV_W'($urandom_range(8000, 6000));
        rec = c.critical_low_mv + $urandom_range(1200);
        if ($urandom_range(99) < 15)
            rec = $urandom_range(MV_TOP);
        c.recovery_mv = MV_W'((rec > MV_TOP) ? MV_TOP : rec);
        c.sunrise_mw  = MW_W'($urandom_range(3000, 50));
        c.dark_mw     = ($urandom_range(99) < 15) ? MW_W'($urandom_range(MW_TOP))
                                                  : MW_W'($urandom_range(c.sunrise_mw));
        c.boost_ticks = ($urandom_range(99) < 20) ? BOOST_W'($urandom_range(255))
                                                  : BOOST_W'($urandom_range(12));
        c.shed_mask   = $urandom();
        return c;
    endfunction

    // full mode cycle twice, charge endpoints, sunrise restarted mid-boost
    task automatic test_mode_sequence();
        send_tick(14'd8400, 16'd0);
        send_tick(14'd16383, 16'd65535);
        send_tick(14'd6001, 16'd501);
        send_tick(14'd6000, 16'd0);
        send_tick(14'd0, 16'd0);
        send_tick(14'd8399, 16'd100);
        send_tick(14'd7399, 16'd600);
        send_tick(14'd6799, 16'd500);
        send_tick(14'd7400, 16'd65535);
        send_tick(14'd7400, 16'd1);
        send_tick(14'd6800, 16'd0);
        send_tick(14'd6800, 16'd700);
        settle();
    endtask

    task automatic test_boost_length();
        cfg_t c;
        c = reset_settings();
        c.boost_ticks = '0;
        apply_settings(c);
        send_tick(14'd8000, 16'd0);
        send_tick(14'd8000, 16'd600);
        send_tick(14'd8000, 16'd0);
        settle();
        c.boost_ticks = 8'd1;
        apply_settings(c);
        send_tick(14'd8000, 16'd600);
        send_tick(14'd8000, 16'd700);
        send_tick(14'd8000, 16'd0);
        settle();
    endtask

    task automatic test_output_backpressure();
        idling_on    = 1'b0;
        hold_request = 300;
        repeat (40) send_tick(pick_voltage(), MW_W'($urandom_range(MW_TOP)));
        settle();
        idling_on = 1'b1;
    endtask

    task automatic test_random_ticks();
        cfg_t c;
        bit   sunny;
        int   run_left;
        sunny    = 1'b0;
        run_left = 0;
        for (int phase = 0; phase < SOAK_PHASES; phase++)
        begin
            c = random_settings();
            if (phase == 1)
                c = '0;
            else if (phase == 2)
                c = '1;
            settle();
            apply_settings(c);
            idling_on = (phase != 3);
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if (run_left == 0)
                begin
                    sunny    = !sunny;
                    run_left = $urandom_range(8, 1);
                end
                run_left--;
                send_tick(pick_voltage(), pick_power(sunny));
            end
        end
        idling_on = 1'b1;
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        item_if.valid          <= 1'b0;
        item_if.bus_voltage_mv <= '0;
        item_if.solar_power_mw <= '0;
        cfg_if.valid           <= 1'b0;
        cfg_if.index           <= '0;
        cfg_if.data            <= '0;
        settings    = reset_settings();
        pm_mode     = MODE_NOMINAL;
        last_solar  = '0;
        boost_count = '0;
        switch_bank = '1;
        safe_bit    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_mode_sequence();
        test_boost_length();
        test_output_backpressure();
        test_random_ticks();
        settle();

        if (mismatches == 0)
            $display("power_mode_load_shed_controller_core: match");
        else
            $display("power_mode_load_shed_controller_core: mismatch");
        $finish;
    end

endmodule
